// File: sv/tcs_pkg.sv
package tcs_pkg;

  localparam int unsigned CMD_W        = 16;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned INPUT_MOTORS = 5;
  localparam int unsigned MOTOR_COUNT_DEF = 5;
  localparam int unsigned INDEX_W      = 3;

  localparam logic [BYTE_W-1:0] START_BYTE  = 8'd101;
  localparam logic [6:0]        LIMIT_RESET = 7'd127;
  localparam logic [7:0]        GAP_RESET   = 8'd60;

  // register index codes, decoded from paddr[2]
  localparam logic REG_MOTOR_LIMIT  = 1'b0;
  localparam logic REG_REVERSAL_GAP = 1'b1;

  typedef logic signed [BYTE_W-1:0] cmd_t;

endpackage

// File: sv/tcs_lane.sv
module tcs_lane (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  logic signed [tcs_pkg::CMD_W-1:0]  req,
  input  logic [6:0]                        motor_limit,
  input  logic [7:0]                        reversal_gap,
  output tcs_pkg::cmd_t                     cmd
);

  tcs_pkg::cmd_t            last_cmd;
  logic signed [15:0]       lim;
  tcs_pkg::cmd_t            clamped;
  logic signed [8:0]        diff;
  logic [8:0]               diff_abs;
  logic                     opposite;

  always_comb begin
    lim = $signed({9'd0, motor_limit});
    if (req > lim) begin
      clamped = $signed({1'b0, motor_limit});
    end else if (req < -lim) begin
      clamped = -$signed({1'b0, motor_limit});
    end else begin
      clamped = req[7:0];
    end
    diff     = 9'(last_cmd) - 9'(clamped);
    diff_abs = diff[8] ? 9'(-diff) : 9'(diff);
    opposite = (last_cmd > 0 && clamped < 0) || (last_cmd < 0 && clamped > 0);
    // drop a hard reversal to zero
    if (opposite && diff_abs > {1'b0, reversal_gap}) begin
      cmd = '0;
    end else begin
      cmd = clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_cmd <= '0;
    end else if (load) begin
      last_cmd <= cmd;
    end
  end

endmodule

// File: sv/tcs_frame.sv
module tcs_frame #(
  parameter int unsigned LANES = tcs_pkg::INPUT_MOTORS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_load,
  input  tcs_pkg::cmd_t [LANES-1:0]               in_cmd,
  output logic                                    in_ready,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [tcs_pkg::BYTE_W-1:0]              m_tdata,
  output logic [tcs_pkg::INDEX_W-1:0]             m_tuser,
  output logic                                    m_tlast
);

  localparam logic [tcs_pkg::INDEX_W-1:0] LAST_IDX = tcs_pkg::INDEX_W'(LANES);

  logic                               pend_valid;
  tcs_pkg::cmd_t [LANES-1:0]          pend_cmd;
  logic                               cur_valid;
  tcs_pkg::cmd_t [LANES-1:0]          cur_cmd;
  logic [tcs_pkg::INDEX_W-1:0]        idx;
  logic                               out_done;
  logic                               cur_free;

  assign out_done = cur_valid && m_tready && (idx == LAST_IDX);
  assign cur_free = !cur_valid || out_done;
  assign in_ready = !pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      cur_valid  <= 1'b0;
      idx        <= '0;
    end else begin
      if (in_load) begin
        pend_valid <= 1'b1;
      end else if (cur_free && pend_valid) begin
        pend_valid <= 1'b0;
      end
      if (cur_free && pend_valid) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (cur_free) begin
        cur_valid <= 1'b0;
      end else if (m_tready) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      pend_cmd <= in_cmd;
    end
    if (cur_free && pend_valid) begin
      cur_cmd <= pend_cmd;
    end
  end

  always_comb begin
    m_tdata = tcs_pkg::START_BYTE;
    for (int k = 0; k < LANES; k++) begin
      if (idx == tcs_pkg::INDEX_W'(k + 1)) begin
        m_tdata = cur_cmd[k];
      end
    end
  end

  assign m_tvalid = cur_valid;
  assign m_tuser  = idx;
  assign m_tlast  = (idx == LAST_IDX);

endmodule

// File: sv/thruster_command_shaper.sv
// Thruster command shaper. Each input word carries five signed 16-bit thruster
// requests; one lane per active motor clamps its request to +/-motor_limit and
// then zeroes it if it reverses the sign of that motor's last command by more
// than reversal_gap, updating the last command on acceptance. The shaped set is
// sent as a frame of MOTOR_COUNT+1 byte words (only the first five motors exist
// at the input, so at most six): start byte 101, then one two's-complement byte
// per motor, tuser giving the byte position and tlast marking the final byte.
// An item costs one output word per frame byte, so sustained rate is one item
// per frame, set by the byte serializer and held back while m_tready is low.
// A one-deep frame buffer takes the next item while the current frame drains;
// an accepted item moves from the pending buffer into the current-frame
// register before its first byte is on the output. Registers: motor_limit at
// address 0 (reset 127), reversal_gap at address 4 (reset 60); write them
// only while no frame is pending.
module thruster_command_shaper #(
  parameter int unsigned MOTOR_COUNT = tcs_pkg::MOTOR_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // APB register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // input: motor_one [15:0], motor_two [31:16], motor_three [47:32],
  //        motor_four [63:48], motor_five [79:64]
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [79:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // output: frame_byte [7:0]
  output logic [7:0]   m_tdata,
  // output: byte_index [2:0]
  output logic [2:0]   m_tuser,
  output logic         m_tlast
);

  // only five requests arrive, so never more than five lanes
  localparam int unsigned LANES = (MOTOR_COUNT < tcs_pkg::INPUT_MOTORS) ?
                                  MOTOR_COUNT : tcs_pkg::INPUT_MOTORS;

  logic [6:0]                 motor_limit;
  logic [7:0]                 reversal_gap;
  logic                       cfg_write;
  logic                       accept;
  tcs_pkg::cmd_t [LANES-1:0]  lane_cmd;

  // Register port: word-aligned decode on paddr[2], no wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_limit  <= tcs_pkg::LIMIT_RESET;
      reversal_gap <= tcs_pkg::GAP_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        tcs_pkg::REG_MOTOR_LIMIT:  motor_limit  <= pwdata[6:0];
        tcs_pkg::REG_REVERSAL_GAP: reversal_gap <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      tcs_pkg::REG_MOTOR_LIMIT:  prdata = {25'd0, motor_limit};
      tcs_pkg::REG_REVERSAL_GAP: prdata = {24'd0, reversal_gap};
      default:                   prdata = '0;
    endcase
  end

  assign accept = s_tvalid && s_tready;

  // One shaping lane per motor; each keeps its own last command.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    tcs_lane u_lane (
      .clk          (clk),
      .rst          (rst),
      .load         (accept),
      .req          ($signed(s_tdata[g*tcs_pkg::CMD_W +: tcs_pkg::CMD_W])),
      .motor_limit  (motor_limit),
      .reversal_gap (reversal_gap),
      .cmd          (lane_cmd[g])
    );
  end

  // Merge the lane results into a frame and stream it out byte by byte.
  tcs_frame #(
    .LANES (LANES)
  ) u_frame (
    .clk      (clk),
    .rst      (rst),
    .in_load  (accept),
    .in_cmd   (lane_cmd),
    .in_ready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// File: sv/tcs_checker.sv
module tcs_checker #(
  parameter int unsigned MOTOR_COUNT = tcs_pkg::MOTOR_COUNT_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  localparam int unsigned LANES = (MOTOR_COUNT < tcs_pkg::INPUT_MOTORS) ?
                                  MOTOR_COUNT : tcs_pkg::INPUT_MOTORS;

  // frame opens with the start byte
  a_start: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == '0 |-> m_tdata == tcs_pkg::START_BYTE)
    else $error("frame does not open with start byte");

  // last flag sits exactly on the final position
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == 3'(LANES))))
    else $error("tlast misplaced in frame");

  // bytes inside a frame follow one another without gaps
  a_seq: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && m_tuser == 3'($past(m_tuser) + 3'd1))
    else $error("frame byte sequence broken");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output word changed");

endmodule

bind thruster_command_shaper tcs_checker #(
  .MOTOR_COUNT (MOTOR_COUNT)
) u_tcs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
